/* src/cau_pkg.sv */
// Shared types and constants for the complex arithmetic unit.
// Holds the operation codes, the pipeline control word and the arctangent table.
// Depends on nothing; every other file imports it.
`timescale 1ns / 1ps

package cau_pkg;

    typedef enum logic [2:0] {
        OP_ADD,
        OP_SUB,
        OP_MUL,
        OP_DIV,
        OP_MAG_A,
        OP_MAG_B,
        OP_ANG_A,
        OP_ANG_B
    } t_op;

    // Control and status that travel with each transaction down the pipeline.
    typedef struct packed {
        logic valid;
        t_op  op;
        logic dz;
        logic neg_re;
        logic neg_im;
        logic big_re;
        logic big_im;
        logic spec;
        logic early_sat;
    } t_ctrl;

    // Angles are kept in signed Q4.30 with enough headroom for +/- pi.
    localparam int ZW = 34;
    localparam logic signed [ZW-1:0] HALF_PI_Q30 = 34'sd1686629713;

    localparam int ATAN_N = 32;
    localparam logic [31:0] ATAN_Q30 [ATAN_N] = '{
        32'd843314857, 32'd497837829, 32'd263043837, 32'd133525159,
        32'd67021687,  32'd33543516,  32'd16775851,  32'd8388437,
        32'd4194283,   32'd2097149,   32'd1048576,   32'd524288,
        32'd262144,    32'd131072,    32'd65536,     32'd32768,
        32'd16384,     32'd8192,      32'd4096,      32'd2048,
        32'd1024,      32'd512,       32'd256,       32'd128,
        32'd64,        32'd32,        32'd16,        32'd8,
        32'd4,         32'd2,         32'd1,         32'd1
    };

endpackage

/* src/cau_front.sv */
// Front end of the complex arithmetic unit: three register stages.
// Products, wide sums, early results, divider and CORDIC setup.
// Depends on cau_pkg.
`timescale 1ns / 1ps

module cau_front #(
    parameter int W = 32,
    parameter int F = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  cau_pkg::t_op                  i_op,
    input  logic signed [W-1:0]           i_a_re,
    input  logic signed [W-1:0]           i_a_im,
    input  logic signed [W-1:0]           i_b_re,
    input  logic signed [W-1:0]           i_b_im,
    output cau_pkg::t_ctrl                o_ctrl,
    output logic [W-1:0]                  o_early_re,
    output logic [W-1:0]                  o_early_im,
    output logic [2*W-1:0]                o_d,
    output logic [2*W-1:0]                o_rem_re,
    output logic [2*W-1:0]                o_rem_im,
    output logic [W-1:0]                  o_lo_re,
    output logic [W-1:0]                  o_lo_im,
    output logic signed [W+2:0]           o_x,
    output logic signed [W+2:0]           o_y,
    output logic signed [cau_pkg::ZW-1:0] o_z
);
    import cau_pkg::*;

    localparam int W2 = 2 * W;
    localparam int XW = W + 3;
    localparam logic [W2:0] MAX_POS = {{(W2 - W + 2){1'b0}}, {(W - 1){1'b1}}};
    localparam logic [W2:0] MAX_NEG = MAX_POS + 1'b1;

    // Returns {saturated, value} for a sign and magnitude pair.
    function automatic logic [W:0] f_clamp(input logic neg, input logic [W2:0] mag);
        logic [W:0] res;
        if (!neg) begin
            res = (mag > MAX_POS) ? {1'b1, MAX_POS[W-1:0]} : {1'b0, mag[W-1:0]};
        end else if (mag > MAX_NEG) begin
            res = {2'b11, {(W - 1){1'b0}}};
        end else begin
            res = {1'b0, W'(0) - mag[W-1:0]};
        end
        return res;
    endfunction

    // Stage 1: products, narrow sums and the CORDIC operands.
    t_ctrl                 r_s1_ctrl;
    t_ctrl                 n_s1_ctrl;
    logic signed [W2-1:0]  r_p1, r_p2, r_p3, r_p4, r_p5, r_p6;
    logic signed [W:0]     r_sum_re, r_sum_im;
    logic signed [W-1:0]   r_cx, r_cy;
    logic signed [W-1:0]   sq_re, sq_im;

    assign sq_re = (i_op == OP_MAG_A) ? i_a_re : i_b_re;
    assign sq_im = (i_op == OP_MAG_A) ? i_a_im : i_b_im;

    always_comb begin
        n_s1_ctrl       = '0;
        n_s1_ctrl.valid = i_valid;
        n_s1_ctrl.op    = i_op;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_ctrl <= '0;
        end else begin
            r_s1_ctrl <= n_s1_ctrl;
        end
    end

    always_ff @(posedge i_clk) begin
        r_p1 <= i_a_re * i_b_re;
        r_p2 <= i_a_im * i_b_im;
        r_p3 <= i_a_im * i_b_re;
        r_p4 <= i_a_re * i_b_im;
        r_p5 <= sq_re * sq_re;
        r_p6 <= sq_im * sq_im;
        if (i_op == OP_SUB) begin
            r_sum_re <= (W + 1)'(i_a_re) - (W + 1)'(i_b_re);
            r_sum_im <= (W + 1)'(i_a_im) - (W + 1)'(i_b_im);
        end else begin
            r_sum_re <= (W + 1)'(i_a_re) + (W + 1)'(i_b_re);
            r_sum_im <= (W + 1)'(i_a_im) + (W + 1)'(i_b_im);
        end
        r_cx <= (i_op == OP_ANG_A) ? i_a_re : i_b_re;
        r_cy <= (i_op == OP_ANG_A) ? i_a_im : i_b_im;
    end

    // Stage 2: wide sums and the CORDIC pre-rotation.
    t_ctrl                 r_s2_ctrl;
    t_ctrl                 n_s2_ctrl;
    logic signed [W2:0]    r_n_re, r_n_im;
    logic [W2-1:0]         r_d;
    logic signed [W:0]     r_s2_sum_re, r_s2_sum_im;
    logic signed [XW-1:0]  r_x, r_y;
    logic signed [ZW-1:0]  r_z;

    logic signed [XW-1:0]  cx, cy, n_x, n_y;
    logic signed [ZW-1:0]  n_z;
    logic                  n_spec;

    always_comb begin
        cx     = XW'(r_cx);
        cy     = XW'(r_cy);
        n_x    = cx;
        n_y    = cy;
        n_z    = '0;
        n_spec = 1'b0;
        if (cy == 0) begin
            n_spec = 1'b1;
            n_z    = (cx < 0) ? (HALF_PI_Q30 <<< 1) : '0;
        end else if (cx == 0) begin
            n_spec = 1'b1;
            n_z    = (cy > 0) ? HALF_PI_Q30 : -HALF_PI_Q30;
        end else if (cx < 0) begin
            if (cy >= 0) begin
                n_x = cy;
                n_y = -cx;
                n_z = HALF_PI_Q30;
            end else begin
                n_x = -cy;
                n_y = cx;
                n_z = -HALF_PI_Q30;
            end
        end
    end

    always_comb begin
        n_s2_ctrl      = r_s1_ctrl;
        n_s2_ctrl.dz   = (r_s1_ctrl.op == OP_DIV) && (r_p5 == 0) && (r_p6 == 0);
        n_s2_ctrl.spec = n_spec;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_ctrl <= '0;
        end else begin
            r_s2_ctrl <= n_s2_ctrl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_s1_ctrl.op == OP_DIV) begin
            r_n_re <= (W2 + 1)'(r_p1) + (W2 + 1)'(r_p2);
            r_n_im <= (W2 + 1)'(r_p3) - (W2 + 1)'(r_p4);
        end else begin
            r_n_re <= (W2 + 1)'(r_p1) - (W2 + 1)'(r_p2);
            r_n_im <= (W2 + 1)'(r_p3) + (W2 + 1)'(r_p4);
        end
        r_d         <= W2'($unsigned(r_p5)) + W2'($unsigned(r_p6));
        r_s2_sum_re <= r_sum_re;
        r_s2_sum_im <= r_sum_im;
        r_x         <= n_x;
        r_y         <= n_y;
        r_z         <= n_z;
    end

    // Stage 3: magnitudes, early results and divider setup.
    logic [W2:0]     m_re, m_im;
    logic [W:0]      s_re_mag, s_im_mag;
    logic [W:0]      c_re, c_im;
    logic            big_re, big_im;
    t_ctrl           r_s3_ctrl;
    t_ctrl           n_s3_ctrl;

    always_comb begin
        m_re     = r_n_re[W2] ? $unsigned(-r_n_re) : $unsigned(r_n_re);
        m_im     = r_n_im[W2] ? $unsigned(-r_n_im) : $unsigned(r_n_im);
        s_re_mag = r_s2_sum_re[W] ? $unsigned(-r_s2_sum_re) : $unsigned(r_s2_sum_re);
        s_im_mag = r_s2_sum_im[W] ? $unsigned(-r_s2_sum_im) : $unsigned(r_s2_sum_im);
        case (r_s2_ctrl.op)
            OP_ADD, OP_SUB: begin
                c_re = f_clamp(r_s2_sum_re[W], (W2 + 1)'(s_re_mag));
                c_im = f_clamp(r_s2_sum_im[W], (W2 + 1)'(s_im_mag));
            end
            OP_MUL: begin
                c_re = f_clamp(r_n_re[W2], m_re >> F);
                c_im = f_clamp(r_n_im[W2], m_im >> F);
            end
            default: begin
                c_re = '0;
                c_im = '0;
            end
        endcase
        // The quotient needs more than W bits exactly when m >= d * 2^(W-F).
        big_re = {W'(0), m_re[W2-1:0]} >= ({W'(0), r_d} << (W - F));
        big_im = {W'(0), m_im[W2-1:0]} >= ({W'(0), r_d} << (W - F));
    end

    always_comb begin
        n_s3_ctrl           = r_s2_ctrl;
        n_s3_ctrl.neg_re    = r_n_re[W2];
        n_s3_ctrl.neg_im    = r_n_im[W2];
        n_s3_ctrl.big_re    = big_re;
        n_s3_ctrl.big_im    = big_im;
        n_s3_ctrl.early_sat = c_re[W] | c_im[W];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_ctrl <= '0;
        end else begin
            r_s3_ctrl <= n_s3_ctrl;
        end
    end

    always_ff @(posedge i_clk) begin
        o_early_re <= c_re[W-1:0];
        o_early_im <= c_im[W-1:0];
        o_d        <= r_d;
        o_rem_re   <= m_re[W2-1:0] >> (W - F);
        o_rem_im   <= m_im[W2-1:0] >> (W - F);
        o_lo_re    <= m_re[W-1:0] << F;
        o_lo_im    <= m_im[W-1:0] << F;
        o_x        <= r_x;
        o_y        <= r_y;
        o_z        <= r_z;
    end

    assign o_ctrl = r_s3_ctrl;

endmodule

/* src/cau_step.sv */
// One pipeline step of the complex arithmetic unit. If STEP < W it advances both
// divider lanes and the square root lane; if STEP < ITERS, also the CORDIC lane.
// Depends on cau_pkg.
`timescale 1ns / 1ps

module cau_step #(
    parameter int W     = 32,
    parameter int ITERS = 16,
    parameter int STEP  = 0
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  cau_pkg::t_ctrl                i_ctrl,
    input  logic [W-1:0]                  i_early_re,
    input  logic [W-1:0]                  i_early_im,
    input  logic [2*W-1:0]                i_d,
    input  logic [2*W-1:0]                i_rem_re,
    input  logic [2*W-1:0]                i_rem_im,
    input  logic [W-1:0]                  i_lo_re,
    input  logic [W-1:0]                  i_lo_im,
    input  logic [W-1:0]                  i_q_re,
    input  logic [W-1:0]                  i_q_im,
    input  logic [2*W-1:0]                i_v,
    input  logic [W+1:0]                  i_srem,
    input  logic [W-1:0]                  i_root,
    input  logic signed [W+2:0]           i_x,
    input  logic signed [W+2:0]           i_y,
    input  logic signed [cau_pkg::ZW-1:0] i_z,
    output cau_pkg::t_ctrl                o_ctrl,
    output logic [W-1:0]                  o_early_re,
    output logic [W-1:0]                  o_early_im,
    output logic [2*W-1:0]                o_d,
    output logic [2*W-1:0]                o_rem_re,
    output logic [2*W-1:0]                o_rem_im,
    output logic [W-1:0]                  o_lo_re,
    output logic [W-1:0]                  o_lo_im,
    output logic [W-1:0]                  o_q_re,
    output logic [W-1:0]                  o_q_im,
    output logic [2*W-1:0]                o_v,
    output logic [W+1:0]                  o_srem,
    output logic [W-1:0]                  o_root,
    output logic signed [W+2:0]           o_x,
    output logic signed [W+2:0]           o_y,
    output logic signed [cau_pkg::ZW-1:0] o_z
);
    import cau_pkg::*;

    localparam int W2 = 2 * W;
    localparam int XW = W + 3;
    localparam bit DIV_ON = STEP < W;
    localparam bit ROT_ON = STEP < ITERS;
    localparam int AI = (STEP < ATAN_N) ? STEP : ATAN_N - 1;
    localparam logic signed [ZW-1:0] ANG = $signed(ZW'(ATAN_Q30[AI]));

    // One restoring division step: returns {quotient bit, new remainder}.
    function automatic logic [W2:0] f_div(input logic [W2-1:0] rem, input logic bit_in,
                                          input logic [W2-1:0] d);
        logic [W2:0] r2;
        logic        ge;
        r2 = {rem, bit_in};
        ge = r2 >= {1'b0, d};
        return {ge, ge ? W2'(r2 - {1'b0, d}) : r2[W2-1:0]};
    endfunction

    logic [W2:0]      dv_re, dv_im;
    logic [W+3:0]     r4, trial;
    logic             sq_ge;
    logic signed [XW-1:0] dx, dy;

    logic [W2-1:0]    n_rem_re, n_rem_im, n_v;
    logic [W-1:0]     n_lo_re, n_lo_im, n_q_re, n_q_im, n_root;
    logic [W+1:0]     n_srem;
    logic signed [XW-1:0] n_x, n_y;
    logic signed [ZW-1:0] n_z;

    always_comb begin
        dv_re = f_div(i_rem_re, i_lo_re[W-1], i_d);
        dv_im = f_div(i_rem_im, i_lo_im[W-1], i_d);
        r4    = {i_srem, i_v[W2-1:W2-2]};
        trial = {2'b00, i_root, 2'b01};
        sq_ge = r4 >= trial;
        dx    = i_y >>> STEP;
        dy    = i_x >>> STEP;

        n_rem_re = i_rem_re;
        n_rem_im = i_rem_im;
        n_lo_re  = i_lo_re;
        n_lo_im  = i_lo_im;
        n_q_re   = i_q_re;
        n_q_im   = i_q_im;
        n_v      = i_v;
        n_srem   = i_srem;
        n_root   = i_root;
        if (DIV_ON) begin
            n_rem_re = dv_re[W2-1:0];
            n_rem_im = dv_im[W2-1:0];
            n_lo_re  = i_lo_re << 1;
            n_lo_im  = i_lo_im << 1;
            n_q_re   = {i_q_re[W-2:0], dv_re[W2]};
            n_q_im   = {i_q_im[W-2:0], dv_im[W2]};
            n_v      = i_v << 2;
            n_srem   = sq_ge ? (W + 2)'(r4 - trial) : r4[W+1:0];
            n_root   = {i_root[W-2:0], sq_ge};
        end

        n_x = i_x;
        n_y = i_y;
        n_z = i_z;
        // Axis cases already carry their final angle and skip the rotations.
        if (ROT_ON && !i_ctrl.spec) begin
            if (!i_y[XW-1]) begin
                n_x = i_x + dx;
                n_y = i_y - dy;
                n_z = i_z + ANG;
            end else begin
                n_x = i_x - dx;
                n_y = i_y + dy;
                n_z = i_z - ANG;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_ctrl <= '0;
        end else begin
            o_ctrl <= i_ctrl;
        end
    end

    always_ff @(posedge i_clk) begin
        o_early_re <= i_early_re;
        o_early_im <= i_early_im;
        o_d        <= i_d;
        o_rem_re   <= n_rem_re;
        o_rem_im   <= n_rem_im;
        o_lo_re    <= n_lo_re;
        o_lo_im    <= n_lo_im;
        o_q_re     <= n_q_re;
        o_q_im     <= n_q_im;
        o_v        <= n_v;
        o_srem     <= n_srem;
        o_root     <= n_root;
        o_x        <= n_x;
        o_y        <= n_y;
        o_z        <= n_z;
    end

endmodule

/* src/cau_back.sv */
// Back end of the complex arithmetic unit: result selection, rounding and clamping.
// Registers the result ports and the strobe.
// Depends on cau_pkg.
`timescale 1ns / 1ps

module cau_back #(
    parameter int W = 32,
    parameter int F = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  cau_pkg::t_ctrl                i_ctrl,
    input  logic [W-1:0]                  i_early_re,
    input  logic [W-1:0]                  i_early_im,
    input  logic [W-1:0]                  i_q_re,
    input  logic [W-1:0]                  i_q_im,
    input  logic [W-1:0]                  i_root,
    input  logic signed [cau_pkg::ZW-1:0] i_z,
    output logic                          o_done,
    output logic signed [W-1:0]           o_result_re,
    output logic signed [W-1:0]           o_result_im,
    output logic                          o_div_by_zero,
    output logic                          o_saturated
);
    import cau_pkg::*;

    localparam int MW = ((W > ZW + 1) ? W : ZW + 1) + 1;
    localparam int S  = 30 - F;
    localparam logic signed [ZW:0] RND = (ZW + 1)'((S > 0) ? (1 << (S - 1)) : 0);
    localparam logic [MW-1:0] MAX_POS = {{(MW - W + 1){1'b0}}, {(W - 1){1'b1}}};
    localparam logic [MW-1:0] MAX_NEG = MAX_POS + 1'b1;

    // Returns {saturated, value}; big forces saturation.
    function automatic logic [W:0] f_clamp(input logic neg, input logic [MW-1:0] mag,
                                           input logic big);
        logic [W:0] res;
        if (!neg) begin
            res = (big || mag > MAX_POS) ? {1'b1, MAX_POS[W-1:0]} : {1'b0, mag[W-1:0]};
        end else if (big || mag > MAX_NEG) begin
            res = {2'b11, {(W - 1){1'b0}}};
        end else begin
            res = {1'b0, W'(0) - mag[W-1:0]};
        end
        return res;
    endfunction

    logic signed [ZW:0] zr;
    logic [ZW:0]        z_mag;
    logic [W:0]         c_re, c_im;
    logic [W-1:0]       n_re, n_im;
    logic               n_dz, n_sat;

    always_comb begin
        zr    = ((ZW + 1)'(i_z) + RND) >>> S;
        z_mag = zr[ZW] ? $unsigned(-zr) : $unsigned(zr);
        c_re  = f_clamp(i_ctrl.neg_re, MW'(i_q_re), i_ctrl.big_re);
        c_im  = f_clamp(i_ctrl.neg_im, MW'(i_q_im), i_ctrl.big_im);
        n_re  = '0;
        n_im  = '0;
        n_dz  = 1'b0;
        n_sat = 1'b0;
        case (i_ctrl.op)
            OP_ADD, OP_SUB, OP_MUL: begin
                n_re  = i_early_re;
                n_im  = i_early_im;
                n_sat = i_ctrl.early_sat;
            end
            OP_DIV: begin
                if (i_ctrl.dz) begin
                    n_dz = 1'b1;
                end else begin
                    n_re  = c_re[W-1:0];
                    n_im  = c_im[W-1:0];
                    n_sat = c_re[W] | c_im[W];
                end
            end
            OP_MAG_A, OP_MAG_B: begin
                c_re  = f_clamp(1'b0, MW'(i_root), 1'b0);
                n_re  = c_re[W-1:0];
                n_sat = c_re[W];
            end
            default: begin
                c_re  = f_clamp(zr[ZW], MW'(z_mag), 1'b0);
                n_re  = c_re[W-1:0];
                n_sat = c_re[W];
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_done        <= 1'b0;
            o_div_by_zero <= 1'b0;
            o_saturated   <= 1'b0;
        end else begin
            o_done        <= i_ctrl.valid;
            o_div_by_zero <= i_ctrl.valid & n_dz;
            o_saturated   <= i_ctrl.valid & n_sat;
        end
    end

    always_ff @(posedge i_clk) begin
        o_result_re <= n_re;
        o_result_im <= n_im;
    end

endmodule

/* src/complex_arithmetic_unit.sv */
// Complex arithmetic unit on signed fixed-point operands, fully pipelined.
// Top level: front end, a chain of iteration steps and the result stage.
// Depends on cau_pkg, cau_front, cau_step and cau_back.
//
// Usage: drive i_op and the four operand ports and raise start for one cycle per
// transaction. busy is always low, so a transaction is accepted at every edge at
// which start is high, back to back with no gaps.
// Each result is shown on the o_ ports for exactly one cycle, marked by o_done, and
// results leave in the order that transactions arrived.
// Every operation takes the same path: three stages form products, sums and the
// divider setup, then one step per quotient bit, root bit or CORDIC iteration, then
// one stage selects, rounds and clamps.
// Throughput: one transaction per cycle.
// Reset (synchronous, active low) drops every transaction in flight; o_done and the
// flags are low afterwards. The receiver cannot stall the block and has to take each
// result in its strobe cycle.
`timescale 1ns / 1ps

module complex_arithmetic_unit #(
    parameter int DATA_WIDTH   = 32,
    parameter int FRAC_BITS    = 16,
    parameter int CORDIC_ITERS = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [2:0]                   i_op,
    input  logic signed [DATA_WIDTH-1:0] i_a_re,
    input  logic signed [DATA_WIDTH-1:0] i_a_im,
    input  logic signed [DATA_WIDTH-1:0] i_b_re,
    input  logic signed [DATA_WIDTH-1:0] i_b_im,
    output logic                         o_done,
    output logic signed [DATA_WIDTH-1:0] o_result_re,
    output logic signed [DATA_WIDTH-1:0] o_result_im,
    output logic                         o_div_by_zero,
    output logic                         o_saturated
);
    import cau_pkg::*;

    localparam int W     = DATA_WIDTH;
    localparam int W2    = 2 * W;
    localparam int XW    = W + 3;
    localparam int NSTEP = (W > CORDIC_ITERS) ? W : CORDIC_ITERS;
    localparam int LAT   = NSTEP + 4;

    t_ctrl                c_s       [NSTEP+1];
    logic [W-1:0]         early_re_s[NSTEP+1];
    logic [W-1:0]         early_im_s[NSTEP+1];
    logic [W2-1:0]        d_s       [NSTEP+1];
    logic [W2-1:0]        rem_re_s  [NSTEP+1];
    logic [W2-1:0]        rem_im_s  [NSTEP+1];
    logic [W-1:0]         lo_re_s   [NSTEP+1];
    logic [W-1:0]         lo_im_s   [NSTEP+1];
    logic [W-1:0]         q_re_s    [NSTEP+1];
    logic [W-1:0]         q_im_s    [NSTEP+1];
    logic [W2-1:0]        v_s       [NSTEP+1];
    logic [W+1:0]         srem_s    [NSTEP+1];
    logic [W-1:0]         root_s    [NSTEP+1];
    logic signed [XW-1:0] x_s       [NSTEP+1];
    logic signed [XW-1:0] y_s       [NSTEP+1];
    logic signed [ZW-1:0] z_s       [NSTEP+1];

    assign busy = 1'b0;

    cau_front #(
        .W (W),
        .F (FRAC_BITS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (start && !busy),
        .i_op       (t_op'(i_op)),
        .i_a_re     (i_a_re),
        .i_a_im     (i_a_im),
        .i_b_re     (i_b_re),
        .i_b_im     (i_b_im),
        .o_ctrl     (c_s[0]),
        .o_early_re (early_re_s[0]),
        .o_early_im (early_im_s[0]),
        .o_d        (d_s[0]),
        .o_rem_re   (rem_re_s[0]),
        .o_rem_im   (rem_im_s[0]),
        .o_lo_re    (lo_re_s[0]),
        .o_lo_im    (lo_im_s[0]),
        .o_x        (x_s[0]),
        .o_y        (y_s[0]),
        .o_z        (z_s[0])
    );

    // The square root works on the same sum of squares that the divider uses.
    assign q_re_s[0] = '0;
    assign q_im_s[0] = '0;
    assign v_s[0]    = d_s[0];
    assign srem_s[0] = '0;
    assign root_s[0] = '0;

    for (genvar k = 0; k < NSTEP; k++) begin : g_step
        cau_step #(
            .W     (W),
            .ITERS (CORDIC_ITERS),
            .STEP  (k)
        ) u_step (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_ctrl     (c_s[k]),
            .i_early_re (early_re_s[k]),
            .i_early_im (early_im_s[k]),
            .i_d        (d_s[k]),
            .i_rem_re   (rem_re_s[k]),
            .i_rem_im   (rem_im_s[k]),
            .i_lo_re    (lo_re_s[k]),
            .i_lo_im    (lo_im_s[k]),
            .i_q_re     (q_re_s[k]),
            .i_q_im     (q_im_s[k]),
            .i_v        (v_s[k]),
            .i_srem     (srem_s[k]),
            .i_root     (root_s[k]),
            .i_x        (x_s[k]),
            .i_y        (y_s[k]),
            .i_z        (z_s[k]),
            .o_ctrl     (c_s[k+1]),
            .o_early_re (early_re_s[k+1]),
            .o_early_im (early_im_s[k+1]),
            .o_d        (d_s[k+1]),
            .o_rem_re   (rem_re_s[k+1]),
            .o_rem_im   (rem_im_s[k+1]),
            .o_lo_re    (lo_re_s[k+1]),
            .o_lo_im    (lo_im_s[k+1]),
            .o_q_re     (q_re_s[k+1]),
            .o_q_im     (q_im_s[k+1]),
            .o_v        (v_s[k+1]),
            .o_srem     (srem_s[k+1]),
            .o_root     (root_s[k+1]),
            .o_x        (x_s[k+1]),
            .o_y        (y_s[k+1]),
            .o_z        (z_s[k+1])
        );
    end

    cau_back #(
        .W (W),
        .F (FRAC_BITS)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ctrl        (c_s[NSTEP]),
        .i_early_re    (early_re_s[NSTEP]),
        .i_early_im    (early_im_s[NSTEP]),
        .i_q_re        (q_re_s[NSTEP]),
        .i_q_im        (q_im_s[NSTEP]),
        .i_root        (root_s[NSTEP]),
        .i_z           (z_s[NSTEP]),
        .o_done        (o_done),
        .o_result_re   (o_result_re),
        .o_result_im   (o_result_im),
        .o_div_by_zero (o_div_by_zero),
        .o_saturated   (o_saturated)
    );

    // Every result strobe stems from a transaction accepted earlier.
    a_fixed_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(start && !busy, LAT))
        else $error("result strobe without a matching transaction");

    a_dz_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_div_by_zero |-> (o_result_re == 0 && o_result_im == 0 && !o_saturated))
        else $error("zero divisor result not cleared");

    a_flags_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_done |-> (!o_div_by_zero && !o_saturated))
        else $error("status flag outside a result cycle");

    a_scalar_im: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (c_s[NSTEP].valid && (c_s[NSTEP].op == OP_MAG_A || c_s[NSTEP].op == OP_MAG_B ||
         c_s[NSTEP].op == OP_ANG_A || c_s[NSTEP].op == OP_ANG_B))
        |=> (o_done && o_result_im == 0))
        else $error("scalar result with nonzero imaginary part");

endmodule
